FILE: sv/sampled_delta_gamma_encoder_core_defines.svh
// ---------------------------------------------------------------------------
// Sampled delta gamma encoder - assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SAMPLED_DELTA_GAMMA_ENCODER_CORE_DEFINES_SVH
`define SAMPLED_DELTA_GAMMA_ENCODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define SDGE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SDGE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SDGE_ASSERT(name, prop, msg)
`define SDGE_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: sv/sdge_pkg.sv
// ---------------------------------------------------------------------------
// Sampled delta gamma encoder - package
// Shared types and constants of the encoder core.
// ---------------------------------------------------------------------------
package sdge_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned PosBits   = 40;
  localparam int unsigned CntBits   = 2;
  localparam int unsigned TdataBits = 112;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SEQ_LENGTH      = 2'd0;
  localparam logic [1:0] CFG_BLOCK_RATE      = 2'd1;
  localparam logic [1:0] CFG_SUPERBLOCK_RATE = 2'd2;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_MARK   = 2'd2
  } sdge_kind_e;

  typedef struct packed {
    sdge_kind_e           kind;
    logic [WordBits-1:0]  code_word;
    logic [WordBits-1:0]  sample_value;
    logic [PosBits-1:0]   bit_position;
    logic                 gap_error;
  } sdge_res_t;

  typedef struct packed {
    logic [31:0] seq_length;
    logic [15:0] block_rate;
    logic [20:0] superblock_rate;
  } sdge_cfg_t;

  typedef struct packed {
    logic [31:0]         prev_value;
    logic [PosBits-1:0]  total_bits;
    logic [PosBits-1:0]  sb_start;
    logic [WordBits-1:0] pend_bits;   // left aligned, pend_cnt valid bits
    logic [4:0]          pend_cnt;
    logic [15:0]         blk_phase;
    logic [20:0]         sb_phase;
  } sdge_state_t;

endpackage

FILE: sv/sdge_encode.sv
// ---------------------------------------------------------------------------
// Sampled delta gamma encoder - encode step
// Works out the results and the next state for one sequence value.
// ---------------------------------------------------------------------------
module sdge_encode import sdge_pkg::*; (
  input  sdge_state_t state_i,
  input  sdge_cfg_t   cfg_i,
  input  logic [31:0] value_i,
  input  logic        last_i,
  output sdge_state_t state_o,
  output sdge_res_t   res_o [MaxRes],
  output logic [CntBits-1:0] cnt_o
);

  logic        is_mark, is_sample, gap_zero, code_path;
  logic [31:0] gap;
  logic [5:0]  len;
  logic [6:0]  code_len, shamt, tot_cnt;
  logic [63:0] code_al;
  logic [95:0] stream;
  logic [31:0] new_pend, fin_pend;
  logic [4:0]  fin_cnt;
  logic [15:0] blk_rate, blk_nx;
  logic [20:0] sb_rate, sb_nx;
  logic [16:0] blk_inc;
  logic [21:0] sb_inc;
  sdge_res_t   cand [4];
  logic [3:0]  cand_vld;
  logic [CntBits-1:0] cnt;

  assign is_mark   = (state_i.sb_phase == '0);
  assign is_sample = (state_i.blk_phase == '0);

  // Gap modulo n, with the wrap when the value steps backwards.
  assign gap = value_i - state_i.prev_value
             + ((value_i < state_i.prev_value) ? cfg_i.seq_length : 32'd0);
  assign gap_zero  = (gap == '0);
  assign code_path = !is_sample && !gap_zero;

  always_comb begin
    len = '0;
    for (int i = 0; i < 32; i++) begin
      if (gap[i]) len = 6'(i + 1);
    end
  end

  // Gamma code is the gap itself in 2*len-1 bits.
  assign code_len = {len, 1'b0} - 7'd1;
  assign shamt    = 7'd64 - code_len;
  assign code_al  = {32'd0, gap} << shamt;
  assign stream   = {state_i.pend_bits, 64'd0} | ({code_al, 32'd0} >> state_i.pend_cnt);
  assign tot_cnt  = {2'd0, state_i.pend_cnt} + code_len;

  always_comb begin
    unique case (tot_cnt[6:5])
      2'd0:    new_pend = stream[95:64];
      2'd1:    new_pend = stream[63:32];
      default: new_pend = stream[31:0];
    endcase
  end

  assign fin_pend = code_path ? new_pend : state_i.pend_bits;
  assign fin_cnt  = code_path ? tot_cnt[4:0] : state_i.pend_cnt;

  // Phase counters, a rate of zero acts as one.
  assign blk_rate = (cfg_i.block_rate == '0) ? 16'd1 : cfg_i.block_rate;
  assign sb_rate  = (cfg_i.superblock_rate == '0) ? 21'd1 : cfg_i.superblock_rate;
  assign blk_inc  = {1'b0, state_i.blk_phase} + 17'd1;
  assign sb_inc   = {1'b0, state_i.sb_phase} + 22'd1;
  assign blk_nx   = (blk_inc >= {1'b0, blk_rate}) ? 16'd0 : blk_inc[15:0];
  assign sb_nx    = (sb_inc >= {1'b0, sb_rate}) ? 21'd0 : sb_inc[20:0];

  always_comb begin
    for (int i = 0; i < 4; i++) cand[i] = '0;
    cand[0].kind         = KIND_MARK;
    cand[0].bit_position = state_i.total_bits;
    if (is_sample) begin
      cand[1].kind         = KIND_SAMPLE;
      cand[1].sample_value = value_i;
      cand[1].bit_position = is_mark ? '0 : state_i.total_bits - state_i.sb_start;
    end else if (gap_zero) begin
      cand[1].kind         = KIND_WORD;
      cand[1].bit_position = state_i.total_bits;
      cand[1].gap_error    = 1'b1;
    end else begin
      cand[1].kind      = KIND_WORD;
      cand[1].code_word = stream[95:64];
    end
    cand[2].kind      = KIND_WORD;
    cand[2].code_word = stream[63:32];
    cand[3].kind      = KIND_WORD;
    cand[3].code_word = fin_pend;

    cand_vld[0] = is_mark;
    cand_vld[1] = is_sample || gap_zero || (tot_cnt[6:5] != 2'd0);
    cand_vld[2] = code_path && (tot_cnt[6:5] == 2'd2);
    cand_vld[3] = last_i && (fin_cnt != '0);
  end

  // Pack the valid candidates in order; anything past three is dropped.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < MaxRes; i++) res_o[i] = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i] && (cnt != 2'd3)) begin
        res_o[cnt] = cand[i];
        cnt        = cnt + 2'd1;
      end
    end
  end
  assign cnt_o = cnt;

  always_comb begin
    state_o = '0;
    if (!last_i) begin
      state_o.prev_value = value_i;
      state_o.total_bits = code_path ? state_i.total_bits + {33'd0, code_len}
                                     : state_i.total_bits;
      state_o.sb_start   = is_mark ? state_i.total_bits : state_i.sb_start;
      state_o.pend_bits  = fin_pend;
      state_o.pend_cnt   = fin_cnt;
      state_o.blk_phase  = blk_nx;
      state_o.sb_phase   = sb_nx;
    end
  end

endmodule

FILE: sv/sdge_out_buf.sv
// ---------------------------------------------------------------------------
// Sampled delta gamma encoder - result buffer
// Holds the results of one value and hands them out one beat at a time.
// ---------------------------------------------------------------------------
`include "sampled_delta_gamma_encoder_core_defines.svh"

module sdge_out_buf import sdge_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  sdge_res_t            res_i [MaxRes],
  input  logic [CntBits-1:0]   cnt_i,
  output logic                 can_load_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataBits-1:0] m_axis_tdata,   // code_word, sample_value, bit_position, gap_error
  output logic [1:0]           m_axis_tuser,   // kind
  output logic                 m_axis_tlast
);

  sdge_res_t          res_q [MaxRes];
  logic [CntBits-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic               last_beat, hs;
  sdge_res_t          cur;

  assign m_axis_tvalid = (idx_q < cnt_q);
  assign last_beat     = (idx_q + 2'd1 == cnt_q);
  assign hs            = m_axis_tvalid && m_axis_tready;
  assign can_load_o    = !m_axis_tvalid || (last_beat && m_axis_tready);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = cnt_i;
      idx_d = '0;
    end else if (hs) begin
      if (last_beat) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < MaxRes; i++) res_q[i] <= res_i[i];
    end
  end

  assign cur          = res_q[idx_q];
  assign m_axis_tdata = {7'd0, cur.gap_error, cur.bit_position, cur.sample_value,
                         cur.code_word};
  assign m_axis_tuser = cur.kind;
  assign m_axis_tlast = last_beat;

  `SDGE_ASSERT(a_idx_below_cnt, m_axis_tvalid |-> (idx_q <= 2'd2), "buffer index past last entry")
  `SDGE_ASSERT(a_more_beats, (hs && !last_beat) |=> m_axis_tvalid, "result dropped mid burst")
  `SDGE_ASSERT(a_load_restarts, load_i |=> (idx_q == '0), "load did not restart the index")
  `SDGE_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (cnt_q == '0), "buffer not empty in reset")

endmodule

FILE: sv/sampled_delta_gamma_encoder_core.sv
// ---------------------------------------------------------------------------
// Sampled delta gamma encoder core
// Gap and Elias-gamma encoder with block samples and superblock marks.
// ---------------------------------------------------------------------------
// Path: an accepted value passes the input register, then the result buffer, which shows its first result.
// Throughput: one value per cycle while each value yields at most one result and
//   m_axis_tready is high; a value yielding more holds the result buffer until all are taken.
// Reset: asynchronous, active low; empties both stages, clears the stream
//   state and loads seq_length 1, block_rate 64, superblock_rate 256.
// ---------------------------------------------------------------------------
`include "sampled_delta_gamma_encoder_core_defines.svh"

module sampled_delta_gamma_encoder_core import sdge_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // seq_value
  input  logic                 s_axis_tlast,   // last
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TdataBits-1:0] m_axis_tdata,   // code_word, sample_value, bit_position, gap_error
  output logic [1:0]           m_axis_tuser,   // kind
  output logic                 m_axis_tlast,   // final_res
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // The input register holds one value; it is encoded in the cycle it moves
  // into the result buffer, so the stream state updates once per value.
  logic        in_vld_q;
  logic [31:0] in_value_q;
  logic        in_last_q;
  logic        load, can_load;

  sdge_cfg_t   cfg_q;
  sdge_state_t state_q, state_d;
  sdge_res_t   res [MaxRes];
  logic [CntBits-1:0] res_cnt;

  assign load          = in_vld_q && can_load;
  assign s_axis_tready = !in_vld_q || load;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_value_q <= s_axis_tdata;
      in_last_q  <= s_axis_tlast;
    end
  end

  // Configuration registers; writes to an unknown index are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seq_length      <= 32'd1;
      cfg_q.block_rate      <= 16'd64;
      cfg_q.superblock_rate <= 21'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEQ_LENGTH:      cfg_q.seq_length      <= cfg_data_i;
        CFG_BLOCK_RATE:      cfg_q.block_rate      <= cfg_data_i[15:0];
        CFG_SUPERBLOCK_RATE: cfg_q.superblock_rate <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  sdge_encode u_encode (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .value_i (in_value_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (res),
    .cnt_o   (res_cnt)
  );

  // Stream state: previous value, bit counters, pending bits and phases.
  // The last value of a stream returns it all to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  sdge_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .cnt_i         (res_cnt),
    .can_load_o    (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `SDGE_ASSERT(a_item_held, (in_vld_q && !load) |=> (in_vld_q && $stable(in_value_q)), "stalled value lost")
  `SDGE_ASSERT(a_state_quiet, !load |=> $stable(state_q), "state moved without a value")
  `SDGE_ASSERT(a_last_clears, (load && in_last_q) |=> (state_q == '0), "last value did not clear state")

endmodule
